>>> hw/rtl/triangle_face_normal_defines.svh
// ----------------------------------------------------------------------------
// triangle_face_normal_defines
// assertion macros shared by the face normal rtl
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define TFN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// shared types and constants of the triangle face normal pipeline
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int FIELD_W              = 16;
    localparam int NORM_W               = 16;
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int CALC_W               = 32;
    localparam int LANES                = 3;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_x;
        logic signed [FIELD_W-1:0] a_y;
        logic signed [FIELD_W-1:0] a_z;
        logic signed [FIELD_W-1:0] b_x;
        logic signed [FIELD_W-1:0] b_y;
        logic signed [FIELD_W-1:0] b_z;
        logic signed [FIELD_W-1:0] c_x;
        logic signed [FIELD_W-1:0] c_y;
        logic signed [FIELD_W-1:0] c_z;
    } tri_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic                     degenerate;
    } normal_t;

    // per-stage control that travels with each beat
    typedef struct packed {
        logic valid;
        logic degenerate;
    } ctl_t;

endpackage

>>> hw/rtl/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// unit face normal of a triangle: cross product, length, scaled quotient
// ----------------------------------------------------------------------------
// Takes one triangle per beat and returns its unit normal in Q1.NORMAL_FRAC_BITS,
// or zeros with the degenerate flag when the cross product vanishes. The pipeline
// accepts a new triangle every cycle unless the result side stalls; it is made of
// five arithmetic stages, one stage per root bit in the square root, one stage per
// quotient bit in the dividers, and the output register.
// A stall on the result side freezes the whole pipeline in place.
`include "triangle_face_normal_defines.svh"

module triangle_face_normal #(
    parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tfn_pkg::tri_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output tfn_pkg::normal_t m_data
);

    localparam int FW   = tfn_pkg::FIELD_W;
    localparam int L    = tfn_pkg::LANES;
    localparam int XW   = (COORD_WIDTH > FW) ? COORD_WIDTH : FW;
    localparam int EW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * EW;
    localparam int DW   = PW + 1;
    localparam int MW   = 2 * COORD_WIDTH + 1;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = SQW + 2;
    localparam int RW   = SUMW / 2;
    localparam int QW   = NORMAL_FRAC_BITS + 1;
    localparam int SBW  = L * (MW + 1);
    localparam int CW   = tfn_pkg::CALC_W;
    localparam int NW   = tfn_pkg::NORM_W;

    logic en;

    // ---- coordinates
    logic [FW-1:0]                 fld [9];
    logic signed [COORD_WIDTH-1:0] v   [9];

    assign fld[0] = s_data.a_x;
    assign fld[1] = s_data.a_y;
    assign fld[2] = s_data.a_z;
    assign fld[3] = s_data.b_x;
    assign fld[4] = s_data.b_y;
    assign fld[5] = s_data.b_z;
    assign fld[6] = s_data.c_x;
    assign fld[7] = s_data.c_y;
    assign fld[8] = s_data.c_z;

    for (genvar i = 0; i < 9; i++) begin : g_coord
        logic [XW-1:0] zx;
        assign zx   = XW'(fld[i]);
        assign v[i] = signed'(zx[COORD_WIDTH-1:0]);
    end

    // ---- stage 1: edges dx1 dy1 dz1 dx2 dy2 dz2
    tfn_pkg::ctl_t         ctl1_reg;
    logic signed [EW-1:0]  e_reg [6];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                e_reg[j]   <= {v[3+j][COORD_WIDTH-1], v[3+j]} - {v[j][COORD_WIDTH-1], v[j]};
                e_reg[3+j] <= {v[6+j][COORD_WIDTH-1], v[6+j]} - {v[j][COORD_WIDTH-1], v[j]};
            end
        end
    end

    // ---- stage 2: the six products
    tfn_pkg::ctl_t        ctl2_reg;
    logic signed [PW-1:0] p_reg [6];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= e_reg[1] * e_reg[5];
            p_reg[1] <= e_reg[2] * e_reg[4];
            p_reg[2] <= e_reg[2] * e_reg[3];
            p_reg[3] <= e_reg[0] * e_reg[5];
            p_reg[4] <= e_reg[0] * e_reg[4];
            p_reg[5] <= e_reg[1] * e_reg[3];
        end
    end

    // ---- stage 3: cross components as sign and magnitude
    tfn_pkg::ctl_t ctl3_reg;
    logic [MW-1:0] mag3_reg [L];
    logic [L-1:0]  neg3_reg;

    for (genvar l = 0; l < L; l++) begin : g_cross
        logic signed [DW-1:0] d;
        logic signed [DW-1:0] a;
        assign d = DW'(p_reg[2*l]) - DW'(p_reg[2*l+1]);
        assign a = d[DW-1] ? -d : d;
        always_ff @(posedge aclk) begin
            if (en) begin
                mag3_reg[l] <= MW'(a);
                neg3_reg[l] <= d[DW-1];
            end
        end
    end

    // ---- stage 4: squares
    tfn_pkg::ctl_t  ctl4_reg;
    logic [SQW-1:0] sq_reg   [L];
    logic [MW-1:0]  mag4_reg [L];
    logic [L-1:0]   neg4_reg;
    logic           zero3;

    assign zero3 = (mag3_reg[0] == '0) && (mag3_reg[1] == '0) && (mag3_reg[2] == '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < L; l++) begin
                sq_reg[l]   <= mag3_reg[l] * mag3_reg[l];
                mag4_reg[l] <= mag3_reg[l];
            end
            neg4_reg <= neg3_reg;
        end
    end

    // ---- stage 5: squared length
    tfn_pkg::ctl_t   ctl5_reg;
    logic [SUMW-1:0] sum_reg;
    logic [MW-1:0]   mag5_reg [L];
    logic [L-1:0]    neg5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg  <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
            mag5_reg <= mag4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // control of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end else if (en) begin
            ctl1_reg <= '{valid: s_valid, degenerate: 1'b0};
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= '{valid: ctl3_reg.valid, degenerate: zero3};
            ctl5_reg <= ctl4_reg;
        end
    end

    // ---- square root, magnitudes and signs ride alongside
    logic [SBW-1:0] side_in;
    logic [SBW-1:0] side_out;
    tfn_pkg::ctl_t  sq_ctl;
    logic [RW-1:0]  root;
    logic [MW-1:0]  mag_q [L];
    logic [L-1:0]   neg_q;

    for (genvar l = 0; l < L; l++) begin : g_side
        assign side_in[l*MW +: MW] = mag5_reg[l];
        assign mag_q[l]            = side_out[l*MW +: MW];
    end
    assign side_in[L*MW +: L] = neg5_reg;
    assign neg_q              = side_out[L*MW +: L];

    tfn_isqrt #(
        .RW  (RW),
        .SBW (SBW)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   (ctl5_reg),
        .in_val   (sum_reg),
        .in_side  (side_in),
        .out_ctl  (sq_ctl),
        .out_root (root),
        .out_side (side_out)
    );

    // ---- division
    tfn_pkg::ctl_t div_ctl;
    logic [QW-1:0] quot [L];
    logic [L-1:0]  quot_neg;

    tfn_div #(
        .MW (MW),
        .RW (RW),
        .QW (QW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   (sq_ctl),
        .in_mag   (mag_q),
        .in_neg   (neg_q),
        .in_root  (root),
        .out_ctl  (div_ctl),
        .out_quot (quot),
        .out_neg  (quot_neg)
    );

    // ---- output register
    logic             m_valid_reg;
    tfn_pkg::normal_t m_data_reg;
    logic [NW-1:0]    nrm [L];

    for (genvar l = 0; l < L; l++) begin : g_sign
        logic [CW-1:0] qe;
        logic [CW-1:0] sv;
        assign qe     = CW'(quot[l]);
        assign sv     = quot_neg[l] ? (CW'(0) - qe) : qe;
        assign nrm[l] = div_ctl.degenerate ? '0 : sv[NW-1:0];
    end

    assign en = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.norm_x     <= nrm[0];
            m_data_reg.norm_y     <= nrm[1];
            m_data_reg.norm_z     <= nrm[2];
            m_data_reg.degenerate <= div_ctl.degenerate;
        end
    end

    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `TFN_ASSERT_IMP(a_degen_zero, m_valid_reg && m_data_reg.degenerate, (m_data_reg.norm_x == '0) && (m_data_reg.norm_y == '0) && (m_data_reg.norm_z == '0), "degenerate beat with non-zero normal")
    `TFN_ASSERT_IMP(a_stall_blocks, m_valid_reg && !m_ready, !s_ready, "input taken while output stalled")

endmodule

>>> hw/rtl/tfn_isqrt.sv
// ----------------------------------------------------------------------------
// tfn_isqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module tfn_isqrt #(
    parameter int RW  = 34,
    parameter int SBW = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  tfn_pkg::ctl_t      in_ctl,
    input  logic [2*RW-1:0]    in_val,
    input  logic [SBW-1:0]     in_side,
    output tfn_pkg::ctl_t      out_ctl,
    output logic [RW-1:0]      out_root,
    output logic [SBW-1:0]     out_side
);

    localparam int REMW = RW + 1;
    localparam int CURW = RW + 3;

    tfn_pkg::ctl_t     ctl_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [REMW-1:0]   rem_reg  [RW];
    logic [2*RW-1:0]   op_reg   [RW];
    logic [SBW-1:0]    side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        tfn_pkg::ctl_t   ctl_prev;
        logic [RW-1:0]   root_prev;
        logic [REMW-1:0] rem_prev;
        logic [2*RW-1:0] op_prev;
        logic [SBW-1:0]  side_prev;
        logic [CURW-1:0] cur;
        logic [CURW-1:0] trial;
        logic [RW-1:0]   root_next;
        logic [REMW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign ctl_prev  = in_ctl;
            assign root_prev = '0;
            assign rem_prev  = '0;
            assign op_prev   = in_val;
            assign side_prev = in_side;
        end else begin : g_rest
            assign ctl_prev  = ctl_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign op_prev   = op_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // bring down the next two operand bits, try (4r + 1)
        // remainder never exceeds twice the root, so RW+1 bits hold it
        assign cur   = {rem_prev, op_prev[2*RW-1 -: 2]};
        assign trial = {1'b0, root_prev, 2'b01};

        always_comb begin
            if (cur >= trial) begin
                rem_next  = REMW'(cur - trial);
                root_next = {root_prev[RW-2:0], 1'b1};
            end else begin
                rem_next  = REMW'(cur);
                root_next = {root_prev[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k] <= '0;
            end else if (en) begin
                ctl_reg[k] <= ctl_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= root_next;
                rem_reg[k]  <= rem_next;
                op_reg[k]   <= op_prev << 2;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_ctl  = ctl_reg[RW-1];
    assign out_root = root_reg[RW-1];
    assign out_side = side_reg[RW-1];

endmodule

>>> hw/rtl/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div
// three-lane pipelined restoring divider for mag * 2^frac / root
// ----------------------------------------------------------------------------
`include "triangle_face_normal_defines.svh"

module tfn_div #(
    parameter int MW = 33,
    parameter int RW = 34,
    parameter int QW = 15
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  tfn_pkg::ctl_t in_ctl,
    input  logic [MW-1:0] in_mag  [tfn_pkg::LANES],
    input  logic [tfn_pkg::LANES-1:0] in_neg,
    input  logic [RW-1:0] in_root,
    output tfn_pkg::ctl_t out_ctl,
    output logic [QW-1:0] out_quot [tfn_pkg::LANES],
    output logic [tfn_pkg::LANES-1:0] out_neg
);

    localparam int L = tfn_pkg::LANES;
    localparam logic [QW-1:0] QMAX = QW'(1) << (QW - 1);

    tfn_pkg::ctl_t ctl_reg  [QW];
    logic [RW-1:0] d_reg    [QW];
    logic [L-1:0]  neg_reg  [QW];
    logic [RW-1:0] rem_reg  [QW][L];
    logic [QW-1:0] q_reg    [QW][L];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        tfn_pkg::ctl_t ctl_prev;
        logic [RW-1:0] d_prev;
        logic [L-1:0]  neg_prev;

        if (k == 0) begin : g_first
            assign ctl_prev = in_ctl;
            assign d_prev   = in_root;
            assign neg_prev = in_neg;
        end else begin : g_rest
            assign ctl_prev = ctl_reg[k-1];
            assign d_prev   = d_reg[k-1];
            assign neg_prev = neg_reg[k-1];
        end

        for (genvar l = 0; l < L; l++) begin : g_lane
            logic [RW-1:0] rem_prev;
            logic [QW-1:0] q_prev;
            logic          bit_in;
            logic [RW:0]   cur;
            logic [RW-1:0] rem_next;
            logic [QW-1:0] q_next;

            // numerator is mag followed by frac zeros: only mag[0] is left to bring down
            if (k == 0) begin : g_first
                assign rem_prev = RW'(in_mag[l] >> 1);
                assign q_prev   = '0;
                assign bit_in   = in_mag[l][0];
            end else begin : g_rest
                assign rem_prev = rem_reg[k-1][l];
                assign q_prev   = q_reg[k-1][l];
                assign bit_in   = 1'b0;
            end

            assign cur = {rem_prev, bit_in};

            always_comb begin
                if (cur >= {1'b0, d_prev}) begin
                    rem_next = RW'(cur - {1'b0, d_prev});
                    q_next   = {q_prev[QW-2:0], 1'b1};
                end else begin
                    rem_next = RW'(cur);
                    q_next   = {q_prev[QW-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k][l] <= rem_next;
                    q_reg[k][l]   <= q_next;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k] <= '0;
            end else if (en) begin
                ctl_reg[k] <= ctl_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k]   <= d_prev;
                neg_reg[k] <= neg_prev;
            end
        end
    end

    assign out_ctl = ctl_reg[QW-1];
    assign out_neg = neg_reg[QW-1];
    for (genvar l = 0; l < L; l++) begin : g_out
        assign out_quot[l] = q_reg[QW-1][l];
    end

    // a zero root must come with the degenerate mark and nothing else
    `TFN_ASSERT_IMP(a_degen_root, in_ctl.valid, in_ctl.degenerate == (in_root == '0), "degenerate mark disagrees with root")
    // a component never exceeds the root, so no quotient passes one
    `TFN_ASSERT_IMP(a_quot_bound, out_ctl.valid && !out_ctl.degenerate, (out_quot[0] <= QMAX) && (out_quot[1] <= QMAX) && (out_quot[2] <= QMAX), "quotient above unit scale")

endmodule

>>> test/tfn_checker.sv
// ----------------------------------------------------------------------------
// tfn_checker
// watches both channels of the face normal block, predicts and compares
// ----------------------------------------------------------------------------
// Every accepted triangle is turned into its expected normal with exact wide
// integer arithmetic. Each accepted result beat is compared field by field
// with the oldest expected normal still waiting.
module tfn_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  tfn_pkg::tri_t    s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  tfn_pkg::normal_t m_data,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    tfn_pkg::normal_t expected_normals[$];

    function automatic tfn_pkg::normal_t face_normal(tfn_pkg::tri_t t);
        longint  e1x, e1y, e1z, e2x, e2y, e2z;
        longint  cr[3];
        bit [79:0] mag[3];
        bit [79:0] sum, sq, num, quo;
        bit [39:0] root, trial;
        bit [tfn_pkg::NORM_W-1:0] comp[3];
        tfn_pkg::normal_t r;
        e1x = longint'(t.b_x) - longint'(t.a_x);
        e1y = longint'(t.b_y) - longint'(t.a_y);
        e1z = longint'(t.b_z) - longint'(t.a_z);
        e2x = longint'(t.c_x) - longint'(t.a_x);
        e2y = longint'(t.c_y) - longint'(t.a_y);
        e2z = longint'(t.c_z) - longint'(t.a_z);
        cr[0] = e1y * e2z - e1z * e2y;
        cr[1] = e1z * e2x - e1x * e2z;
        cr[2] = e1x * e2y - e1y * e2x;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (cr[i] < 0) ? 80'(-cr[i]) : 80'(cr[i]);
            sum += mag[i] * mag[i];
        end
        r = '0;
        if (sum == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        // floor square root, one root bit at a time
        root = '0;
        for (int b = 39; b >= 0; b--) begin
            trial = root | (40'd1 << b);
            sq = 80'(trial) * 80'(trial);
            if (sq <= sum) root = trial;
        end
        for (int i = 0; i < 3; i++) begin
            num = mag[i] << tfn_pkg::NORMAL_FRAC_BITS_DEF;
            quo = num / 80'(root);
            if (cr[i] < 0) quo = 80'd0 - quo;
            comp[i] = quo[tfn_pkg::NORM_W-1:0];
        end
        r.norm_x = comp[0];
        r.norm_y = comp[1];
        r.norm_z = comp[2];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        tfn_pkg::normal_t want;
        if (!aresetn) begin
            errors  = 0;
            pending = 0;
        end else begin
            if (s_valid && s_ready) expected_normals.push_back(face_normal(s_data));
            if (m_valid && m_ready) begin
                if (expected_normals.size() == 0) begin
                    $display("%0t result beat with nothing expected", $realtime);
                    errors++;
                end else begin
                    want = expected_normals.pop_front();
                    if (m_data.norm_x !== want.norm_x)
                        report_mismatch("norm_x", m_data.norm_x, want.norm_x);
                    if (m_data.norm_y !== want.norm_y)
                        report_mismatch("norm_y", m_data.norm_y, want.norm_y);
                    if (m_data.norm_z !== want.norm_z)
                        report_mismatch("norm_z", m_data.norm_z, want.norm_z);
                    if (m_data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", m_data.degenerate, want.degenerate);
                end
            end
            pending = expected_normals.size();
        end
    end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the triangle face normal block
// ----------------------------------------------------------------------------
// Sends directed triangles (extremes, axis faces, degenerate shapes) and then
// random ones, mostly small or full range with some degenerate, while both
// channels idle at random. The checker does the prediction and comparison.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TRIANGLES = 1530;
    localparam int IDLE_LIMIT       = 5000;
    localparam int DRAIN_CYCLES     = 120;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    tfn_pkg::tri_t    s_data;
    logic             m_valid;
    logic             m_ready;
    tfn_pkg::normal_t m_data;
    int               errors;
    int               pending;
    bit               quiet_phase;

    triangle_face_normal DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    tfn_checker checker_i (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .errors  (errors),
        .pending (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_triangle(tfn_pkg::tri_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    function automatic tfn_pkg::tri_t make_triangle(int ax, int ay, int az,
                                                    int bx, int by, int bz,
                                                    int cx, int cy, int cz);
        tfn_pkg::tri_t t;
        t.a_x = 16'(ax); t.a_y = 16'(ay); t.a_z = 16'(az);
        t.b_x = 16'(bx); t.b_y = 16'(by); t.b_z = 16'(bz);
        t.c_x = 16'(cx); t.c_y = 16'(cy); t.c_z = 16'(cz);
        return t;
    endfunction

    function automatic logic signed [15:0] coord(bit narrow);
        if (narrow) return 16'($signed($urandom_range(0, 1023)) - 512);
        return 16'($urandom);
    endfunction

    function automatic tfn_pkg::tri_t random_triangle();
        tfn_pkg::tri_t t;
        int   kind;
        bit   narrow;
        kind   = $urandom_range(0, 9);
        narrow = $urandom_range(0, 1);
        t = make_triangle(coord(narrow), coord(narrow), coord(narrow),
                          coord(narrow), coord(narrow), coord(narrow),
                          coord(narrow), coord(narrow), coord(narrow));
        if (kind == 0) begin
            // two vertices coincide
            t.c_x = t.a_x; t.c_y = t.a_y; t.c_z = t.a_z;
        end else if (kind == 1) begin
            // third vertex on the line through the first two
            t.c_x = t.b_x + t.b_x - t.a_x;
            t.c_y = t.b_y + t.b_y - t.a_y;
            t.c_z = t.b_z + t.b_z - t.a_z;
        end else if (kind == 2) begin
            t.a_z = t.a_x; t.b_z = t.a_x; t.c_z = t.a_x;
        end
        return t;
    endfunction

    // result side back-pressure
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // watchdog on cycles where no beat moves
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        quiet_phase = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_triangle(make_triangle(0, 0, 0, 0, 256, 0, 256, 0, 0));
        send_triangle(make_triangle(0, 0, 0, 0, 256, 0, 0, 0, 256));
        send_triangle(make_triangle(0, 0, 0, 0, 0, 256, 256, 0, 0));
        send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_triangle(make_triangle(-32768, -32768, -32768, 32767, -32768, -32768,
                                    -32768, 32767, -32768));
        send_triangle(make_triangle(32767, 32767, 32767, -32768, 32767, 32767,
                                    32767, -32768, 32767));
        send_triangle(make_triangle(-32768, -32768, -32768, 32767, 32767, -32768,
                                    -32768, 32767, 32767));
        send_triangle(make_triangle(32767, -32768, 32767, -32768, 32767, -32768,
                                    32767, 32767, -32768));
        send_triangle(make_triangle(-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768));
        send_triangle(make_triangle(-32768, -32768, -32768, 32767, 32767, 32767,
                                    -32768, -32768, -32768));
        send_triangle(make_triangle(0, 0, 0, 100, 200, 300, 200, 400, 600));
        send_triangle(make_triangle(5, 5, 5, 5, 5, 5, 9, 1, -3));
        send_triangle(make_triangle(1, 2, 3, 4, 6, 9, 1, 2, 4));
        send_triangle(make_triangle(0, 0, 0, 3, 0, 0, 0, 4, 0));
        send_triangle(make_triangle(0, 0, 0, 1, 1, 0, 1, 0, 1));
        send_triangle(make_triangle(-1, -1, -1, -1, -1, -1, -1, -1, -1));

        for (int i = 0; i < RANDOM_TRIANGLES; i++) begin
            if (i % 300 == 150) quiet_phase = ~quiet_phase;
            if (i == RANDOM_TRIANGLES / 2) begin
                // let the pipeline drain before carrying on
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            send_triangle(random_triangle());
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
